/* hdl/csum_pkg.sv */
// shared types and constants for the tensor cumulative sum block
`timescale 1ns / 1ps

package csum_pkg;

    localparam int DATA_W     = 32;
    localparam int CNT_W      = 13;
    localparam int AFTER_W    = 11;
    localparam int AXIS_POS_W = 12;
    localparam int ADDR_W     = 5;

    localparam logic [CNT_W-1:0] AXIS_MAX  = 13'd4096;
    localparam logic [CNT_W-1:0] BLOCK_MAX = 13'd4096;

    // register indexes on the configuration port
    localparam logic [2:0] REG_BEFORE  = 3'd0;
    localparam logic [2:0] REG_AXIS    = 3'd1;
    localparam logic [2:0] REG_AFTER   = 3'd2;
    localparam logic [2:0] REG_EXCL    = 3'd3;
    localparam logic [2:0] REG_REVERSE = 3'd4;

    typedef struct packed {
        logic [CNT_W-1:0]   before_axis_count;
        logic [CNT_W-1:0]   axis_length;
        logic [AFTER_W-1:0] after_axis_count;
        logic               exclusive_mode;
        logic               reverse_mode;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] dest_index;
        logic              first_axis;
        logic              final_element;
    } item_info_t;

endpackage

/* hdl/tensor_axis_cumulative_sum_top.sv */
// top level of the tensor cumulative sum block
//
//  channel   | dir | beat fields
//  ----------+-----+---------------------------------------------------------
//  s_*       | in  | tdata[31:0] element_value
//  m_*       | out | tdata[31:0] running_sum, tdata[63:32] dest_index,
//            |     | tlast final_element
//  apb       | in  | regs at 0x00 before, 0x04 axis, 0x08 after,
//            |     | 0x0c exclusive, 0x10 reverse
//
//  one beat per cycle sustained unless the output stalls or a size product settles;
//  beats pass the registered accumulator ram read, then the output register
//  no clearing pass after reset; input ready is high as soon as reset is released
//  a register write holds s_tready low while the tensor size
//  product settles; a stalled output keeps one beat in the accumulate stage
`timescale 1ns / 1ps

module tensor_axis_cumulative_sum_top #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,    // element_value
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [63:0]                 m_tdata,    // running_sum, dest_index
    output logic                        m_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [csum_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    csum_pkg::cfg_t                 cfg;
    csum_pkg::item_info_t           info;
    logic [csum_pkg::DATA_W-1:0]    total;
    logic                           busy;
    logic                           restart;
    logic                           accept;
    logic                           space;
    logic [csum_pkg::AFTER_W-1:0]   slot_pos;
    logic [SLOT_W-1:0]              sidx;
    logic                           wr_en;
    logic [SLOT_W-1:0]              wr_addr;
    logic [csum_pkg::DATA_W-1:0]    wr_data;
    logic [csum_pkg::DATA_W-1:0]    rd_data;
    logic [csum_pkg::DATA_W-1:0]    out_sum;
    logic [csum_pkg::DATA_W-1:0]    out_dest;

    assign pready   = 1'b1;
    assign s_tready = space && !busy;
    assign accept   = s_tvalid && s_tready;
    assign sidx     = SLOT_W'(slot_pos);
    assign m_tdata  = {out_dest, out_sum};

    csum_cfg #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg),
        .total   (total),
        .busy    (busy),
        .restart (restart)
    );

    csum_trav u_trav (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .total    (total),
        .restart  (restart),
        .advance  (accept),
        .slot_pos (slot_pos),
        .info     (info)
    );

    csum_ram #(
        .WIDTH (csum_pkg::DATA_W),
        .DEPTH (MAX_SLOTS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (accept),
        .raddr (sidx),
        .rdata (rd_data)
    );

    csum_pipe #(
        .SLOT_W (SLOT_W)
    ) u_pipe (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .in_elem        (s_tdata),
        .in_info        (info),
        .in_sidx        (sidx),
        .exclusive_mode (cfg.exclusive_mode),
        .rd_data        (rd_data),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .space          (space),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_sum        (out_sum),
        .out_dest       (out_dest),
        .out_last       (m_tlast)
    );

    a_no_accept_while_settling : assert property (
        @(posedge clk) disable iff (!rst_n) busy |-> !accept
    ) else $error("input beat taken while size product settles");

    a_fwd_last_index : assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast && !cfg.reverse_mode) |-> (out_dest == total - 32'd1)
    ) else $error("last beat of tensor not at highest flat index");

    a_rev_last_index : assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast && cfg.reverse_mode) |-> (out_dest == '0)
    ) else $error("last beat of reversed tensor not at index zero");

endmodule

/* hdl/csum_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module csum_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/csum_cfg.sv */
// configuration registers, tensor size product and settle window
`timescale 1ns / 1ps

module csum_cfg #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [csum_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output csum_pkg::cfg_t                cfg,
    output logic [csum_pkg::DATA_W-1:0]   total,
    output logic                          busy,
    output logic                          restart
);

    csum_pkg::cfg_t                   cfg_reg, cfg_next;
    logic [1:0]                       settle_reg, settle_next;
    logic [2*csum_pkg::CNT_W-1:0]     ab_reg;
    logic [csum_pkg::DATA_W-1:0]      total_reg;
    logic [csum_pkg::CNT_W+csum_pkg::CNT_W+csum_pkg::AFTER_W-1:0] abc_full;
    logic                             wr;
    logic [2:0]                       idx;
    logic [csum_pkg::CNT_W-1:0]       wv13;
    logic [csum_pkg::AFTER_W-1:0]     wv11;

    assign wr   = psel && penable && pwrite;
    assign idx  = paddr[4:2];
    assign wv13 = pwdata[csum_pkg::CNT_W-1:0];
    assign wv11 = pwdata[csum_pkg::AFTER_W-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        restart  = 1'b0;
        if (wr)
        begin
            restart = 1'b1;
            case (idx)
                csum_pkg::REG_BEFORE:
                begin
                    if (wv13 == '0)
                        cfg_next.before_axis_count = 13'd1;
                    else if (wv13 > csum_pkg::BLOCK_MAX)
                        cfg_next.before_axis_count = csum_pkg::BLOCK_MAX;
                    else
                        cfg_next.before_axis_count = wv13;
                end
                csum_pkg::REG_AXIS:
                begin
                    if (wv13 == '0)
                        cfg_next.axis_length = 13'd1;
                    else if (wv13 > csum_pkg::AXIS_MAX)
                        cfg_next.axis_length = csum_pkg::AXIS_MAX;
                    else
                        cfg_next.axis_length = wv13;
                end
                csum_pkg::REG_AFTER:
                begin
                    if (wv11 == '0)
                        cfg_next.after_axis_count = 11'd1;
                    else if ({21'b0, wv11} > 32'(MAX_SLOTS))
                        cfg_next.after_axis_count = csum_pkg::AFTER_W'(MAX_SLOTS);
                    else
                        cfg_next.after_axis_count = wv11;
                end
                csum_pkg::REG_EXCL:
                    cfg_next.exclusive_mode = pwdata[0];
                csum_pkg::REG_REVERSE:
                    cfg_next.reverse_mode = pwdata[0];
                default:
                    restart = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        if (restart)
            settle_next = 2'd2;
        else if (settle_reg != 2'd0)
            settle_next = settle_reg - 2'd1;
        else
            settle_next = settle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.before_axis_count <= 13'd1;
            cfg_reg.axis_length       <= 13'd1;
            cfg_reg.after_axis_count  <= 11'd1;
            cfg_reg.exclusive_mode    <= 1'b0;
            cfg_reg.reverse_mode      <= 1'b0;
            settle_reg                <= 2'd0;
        end
        else
        begin
            cfg_reg    <= cfg_next;
            settle_reg <= settle_next;
        end
    end

    // element count of the tensor, two registered multiplies
    assign abc_full = ab_reg * cfg_reg.after_axis_count;

    always_ff @(posedge clk)
    begin
        ab_reg    <= cfg_reg.before_axis_count * cfg_reg.axis_length;
        total_reg <= abc_full[csum_pkg::DATA_W-1:0];
    end

    always_comb
    begin
        case (idx)
            csum_pkg::REG_BEFORE:  prdata = {19'b0, cfg_reg.before_axis_count};
            csum_pkg::REG_AXIS:    prdata = {19'b0, cfg_reg.axis_length};
            csum_pkg::REG_AFTER:   prdata = {21'b0, cfg_reg.after_axis_count};
            csum_pkg::REG_EXCL:    prdata = {31'b0, cfg_reg.exclusive_mode};
            csum_pkg::REG_REVERSE: prdata = {31'b0, cfg_reg.reverse_mode};
            default:               prdata = 32'b0;
        endcase
    end

    assign cfg   = cfg_reg;
    assign total = total_reg;
    assign busy  = (settle_reg != 2'd0);

endmodule

/* hdl/csum_trav.sv */
// traversal position counters and destination index
`timescale 1ns / 1ps

module csum_trav (
    input  logic                               clk,
    input  logic                               rst_n,
    input  csum_pkg::cfg_t                     cfg,
    input  logic [csum_pkg::DATA_W-1:0]        total,
    input  logic                               restart,
    input  logic                               advance,
    output logic [csum_pkg::AFTER_W-1:0]       slot_pos,
    output csum_pkg::item_info_t               info
);

    logic [csum_pkg::AFTER_W-1:0]    slot_reg, slot_next;
    logic [csum_pkg::AXIS_POS_W-1:0] axis_reg, axis_next;
    logic [csum_pkg::AXIS_POS_W-1:0] block_reg, block_next;
    logic [csum_pkg::DATA_W-1:0]     trav_reg, trav_next;
    logic                            last_slot;
    logic                            last_axis;
    logic                            last_block;
    logic                            fin;

    assign last_slot  = ({1'b0, slot_reg} + 12'd1) >= {1'b0, cfg.after_axis_count};
    assign last_axis  = ({1'b0, axis_reg} + 13'd1) >= cfg.axis_length;
    assign last_block = ({1'b0, block_reg} + 13'd1) >= cfg.before_axis_count;
    assign fin        = last_slot && last_axis && last_block;

    // reversed order: flat index is total - 1 - count
    assign info.dest_index    = cfg.reverse_mode ? (total + ~trav_reg) : trav_reg;
    assign info.first_axis    = (axis_reg == '0);
    assign info.final_element = fin;
    assign slot_pos           = slot_reg;

    always_comb
    begin
        slot_next  = slot_reg;
        axis_next  = axis_reg;
        block_next = block_reg;
        trav_next  = trav_reg;
        if (restart || (advance && fin))
        begin
            slot_next  = '0;
            axis_next  = '0;
            block_next = '0;
            trav_next  = '0;
        end
        else if (advance)
        begin
            trav_next = trav_reg + 32'd1;
            if (!last_slot)
            begin
                slot_next = slot_reg + 11'd1;
            end
            else
            begin
                slot_next = '0;
                if (!last_axis)
                begin
                    axis_next = axis_reg + 12'd1;
                end
                else
                begin
                    axis_next  = '0;
                    block_next = block_reg + 12'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            axis_reg  <= '0;
            block_reg <= '0;
            trav_reg  <= '0;
        end
        else
        begin
            slot_reg  <= slot_next;
            axis_reg  <= axis_next;
            block_reg <= block_next;
            trav_reg  <= trav_next;
        end
    end

endmodule

/* hdl/csum_pipe.sv */
// accumulate stage with bypass and output register
`timescale 1ns / 1ps

module csum_pipe #(
    parameter int SLOT_W = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [csum_pkg::DATA_W-1:0]   in_elem,
    input  csum_pkg::item_info_t          in_info,
    input  logic [SLOT_W-1:0]             in_sidx,
    input  logic                          exclusive_mode,
    input  logic [csum_pkg::DATA_W-1:0]   rd_data,
    output logic                          wr_en,
    output logic [SLOT_W-1:0]             wr_addr,
    output logic [csum_pkg::DATA_W-1:0]   wr_data,
    output logic                          space,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [csum_pkg::DATA_W-1:0]   out_sum,
    output logic [csum_pkg::DATA_W-1:0]   out_dest,
    output logic                          out_last
);

    logic                          s1_valid_reg, s1_valid_next;
    logic [csum_pkg::DATA_W-1:0]   s1_elem_reg;
    csum_pkg::item_info_t          s1_info_reg;
    logic [SLOT_W-1:0]             s1_sidx_reg;
    logic                          fwd_reg;
    logic [csum_pkg::DATA_W-1:0]   fwd_data_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [csum_pkg::DATA_W-1:0]   out_sum_reg;
    logic [csum_pkg::DATA_W-1:0]   out_dest_reg;
    logic                          out_last_reg;
    logic                          s1_move;
    logic [csum_pkg::DATA_W-1:0]   prior;
    logic [csum_pkg::DATA_W-1:0]   sum;

    assign s1_move = s1_valid_reg && (!out_valid_reg || out_ready);
    assign space   = !s1_valid_reg || s1_move;

    always_comb
    begin
        if (s1_info_reg.first_axis)
            prior = '0;
        else if (fwd_reg)
            prior = fwd_data_reg;
        else
            prior = rd_data;
    end

    assign sum = prior + s1_elem_reg;

    assign wr_en   = s1_move;
    assign wr_addr = s1_sidx_reg;
    assign wr_data = sum;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_move)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                // same slot written by the beat leaving now, ram read is stale
                fwd_reg <= s1_move && (s1_sidx_reg == in_sidx);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_elem_reg  <= in_elem;
            s1_info_reg  <= in_info;
            s1_sidx_reg  <= in_sidx;
            fwd_data_reg <= sum;
        end
        if (s1_move)
        begin
            out_sum_reg  <= exclusive_mode ? prior : sum;
            out_dest_reg <= s1_info_reg.dest_index;
            out_last_reg <= s1_info_reg.final_element;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_sum   = out_sum_reg;
    assign out_dest  = out_dest_reg;
    assign out_last  = out_last_reg;

endmodule
